@@ design/pci_pkg.sv @@
// Shared types, constants and register codes for the clamped-integrator PID block.
`timescale 1ns / 1ps
`default_nettype none
package pci_pkg;

    // Field and register widths
    localparam int DataW  = 32;
    localparam int GainW  = 31;
    localparam int RateW  = 16;
    localparam int IdxW   = 3;
    localparam int ProdW  = 65;
    localparam int AccW   = 49;

    // Register indexes
    localparam logic [IdxW-1:0] RegKp     = 3'd0;
    localparam logic [IdxW-1:0] RegKi     = 3'd1;
    localparam logic [IdxW-1:0] RegKd     = 3'd2;
    localparam logic [IdxW-1:0] RegRate   = 3'd3;
    localparam logic [IdxW-1:0] RegPeriod = 3'd4;
    localparam logic [IdxW-1:0] RegLimit  = 3'd5;

    // Register reset values
    localparam logic [GainW-1:0] KpReset     = 31'd65536;
    localparam logic [GainW-1:0] KiReset     = 31'd0;
    localparam logic [GainW-1:0] KdReset     = 31'd0;
    localparam logic [RateW-1:0] RateReset   = 16'd100;
    localparam logic [RateW-1:0] PeriodReset = 16'd655;
    localparam logic [GainW-1:0] LimitReset  = 31'd65536;

    localparam logic signed [DataW-1:0] SatMax = 32'sh7FFF_FFFF;
    localparam logic signed [DataW-1:0] SatMin = 32'sh8000_0000;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_RATE,
        S_MUL_PER,
        S_INTEG,
        S_MUL_KD,
        S_MUL_KI,
        S_SUM,
        S_DONE,
        S_CLR
    } state_t;

    // Multiplier operand selection
    typedef enum logic [2:0] {
        MUL_RATE,
        MUL_PER,
        MUL_KP,
        MUL_KD,
        MUL_KI
    } mul_sel_t;

    // Configuration register set
    typedef struct packed {
        logic [GainW-1:0] kp;
        logic [GainW-1:0] ki;
        logic [GainW-1:0] kd;
        logic [RateW-1:0] rate;
        logic [RateW-1:0] period;
        logic [GainW-1:0] limit;
    } cfg_t;

    // Controller to datapath commands
    typedef struct packed {
        logic     capture;
        logic     clear;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     save_deriv;
        logic     save_integ;
        logic     acc_load;
        logic     acc_add;
        logic     out_load;
        logic     out_zero;
    } cmd_t;

endpackage
`default_nettype wire

@@ design/pci_regs.sv @@
// Configuration register file for the PID block.
`timescale 1ns / 1ps
`default_nettype none
module pci_regs (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write_en,
    input  wire logic [pci_pkg::IdxW-1:0]  cfg_index,
    input  wire logic [pci_pkg::GainW-1:0] cfg_data,
    output pci_pkg::cfg_t               cfg
);
    import pci_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode one register write, unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            case (cfg_index)
                RegKp:     cfg_next.kp     = cfg_data;
                RegKi:     cfg_next.ki     = cfg_data;
                RegKd:     cfg_next.kd     = cfg_data;
                RegRate:   cfg_next.rate   = cfg_data[RateW-1:0];
                RegPeriod: cfg_next.period = cfg_data[RateW-1:0];
                RegLimit:  cfg_next.limit  = cfg_data;
                default:   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kp     <= KpReset;
            cfg_reg.ki     <= KiReset;
            cfg_reg.kd     <= KdReset;
            cfg_reg.rate   <= RateReset;
            cfg_reg.period <= PeriodReset;
            cfg_reg.limit  <= LimitReset;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

@@ design/pci_ctrl.sv @@
// Sequencer for the PID step: steps the shared multiplier and drives the handshakes.
`timescale 1ns / 1ps
`default_nettype none
module pci_ctrl (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire logic      action,
    input  wire logic      out_stall,
    output logic           in_stall,
    output logic           out_valid,
    output pci_pkg::cmd_t  cmd
);
    import pci_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;
    logic   room;

    assign accept = in_valid && (state_reg == S_IDLE);
    assign room   = !out_valid_reg || !out_stall;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = action ? S_CLR : S_MUL_RATE;
                end
            end
            S_MUL_RATE: state_next = S_MUL_PER;
            S_MUL_PER:  state_next = S_INTEG;
            S_INTEG:    state_next = S_MUL_KD;
            S_MUL_KD:   state_next = S_MUL_KI;
            S_MUL_KI:   state_next = S_SUM;
            S_SUM:      state_next = S_DONE;
            S_DONE:
            begin
                if (room)
                begin
                    state_next = S_IDLE;
                end
            end
            S_CLR:
            begin
                if (room)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // Commands to the datapath
    always_comb
    begin
        cmd            = '0;
        cmd.mul_sel    = MUL_RATE;
        cmd.capture    = accept && !action;
        cmd.clear      = accept && action;
        case (state_reg)
            S_MUL_RATE:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_RATE;
            end
            S_MUL_PER:
            begin
                cmd.mul_en     = 1'b1;
                cmd.mul_sel    = MUL_PER;
                cmd.save_deriv = 1'b1;
            end
            S_INTEG:
            begin
                cmd.mul_en     = 1'b1;
                cmd.mul_sel    = MUL_KP;
                cmd.save_integ = 1'b1;
            end
            S_MUL_KD:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_KD;
                cmd.acc_load = 1'b1;
            end
            S_MUL_KI:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_KI;
                cmd.acc_add = 1'b1;
            end
            S_SUM:
            begin
                cmd.acc_add = 1'b1;
            end
            S_DONE:
            begin
                cmd.out_load = room;
            end
            S_CLR:
            begin
                cmd.out_load = room;
                cmd.out_zero = 1'b1;
            end
            default:
            begin
                cmd.mul_en = 1'b0;
            end
        endcase
    end

    // Output valid: set on load, dropped once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    // An accepted item keeps the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_stall)
        else $error("block not busy after accepting an item");

    // A new result only appears after a finishing state
    a_rise_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_DONE || $past(state_reg) == S_CLR))
        else $error("result raised outside a finishing state");

    // A finished item waits while the output register is full and stalled
    a_hold_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_valid_reg && out_stall) |=> state_reg == S_DONE)
        else $error("result overwritten while stalled");

endmodule
`default_nettype wire

@@ design/pci_dpath.sv @@
// PID datapath: error, derivative, clamped integral and gain sum on one multiplier.
`timescale 1ns / 1ps
`default_nettype none
module pci_dpath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  pci_pkg::cmd_t                      cmd,
    input  pci_pkg::cfg_t                      cfg,
    input  wire logic signed [pci_pkg::DataW-1:0] measured,
    input  wire logic signed [pci_pkg::DataW-1:0] setpoint,
    output logic signed [pci_pkg::DataW-1:0]   drive,
    output logic signed [pci_pkg::DataW-1:0]   error_value,
    output logic signed [pci_pkg::DataW-1:0]   integral_value
);
    import pci_pkg::*;

    // Loop state
    logic signed [DataW-1:0] prev_meas_reg;
    logic signed [DataW-1:0] integral_reg;

    // Working registers
    logic signed [DataW-1:0] err_reg;
    logic signed [DataW:0]   diff_reg;
    logic signed [DataW-1:0] deriv_reg;
    logic signed [ProdW-1:0] prod_reg;
    logic signed [AccW-1:0]  acc_reg;

    // Output registers
    logic signed [DataW-1:0] drive_reg;
    logic signed [DataW-1:0] err_out_reg;
    logic signed [DataW-1:0] integ_out_reg;

    logic signed [DataW:0]   err_wide;
    logic signed [DataW-1:0] err_sat;
    logic signed [DataW:0]   a_sel;
    logic signed [DataW-1:0] b_sel;
    logic signed [ProdW-1:0] mul_out;
    logic                    deriv_ovf;
    logic signed [DataW-1:0] deriv_sat;
    logic signed [DataW-1:0] incr;
    logic signed [DataW:0]   integ_wide;
    logic signed [DataW:0]   lim_pos33;
    logic signed [DataW:0]   lim_neg33;
    logic signed [DataW-1:0] integ_clamped;
    logic signed [AccW-1:0]  term;
    logic                    acc_ovf;
    logic signed [DataW-1:0] acc_sat;
    logic signed [DataW-1:0] lim_pos32;
    logic signed [DataW-1:0] lim_neg32;
    logic signed [DataW-1:0] drive_clamped;

    // Error, saturated to 32 bits
    assign err_wide = 33'(setpoint) - 33'(measured);
    assign err_sat  = (err_wide[DataW] != err_wide[DataW-1])
                      ? (err_wide[DataW] ? SatMin : SatMax) : err_wide[DataW-1:0];

    // Multiplier operand select
    always_comb
    begin
        case (cmd.mul_sel)
            MUL_RATE:
            begin
                a_sel = diff_reg;
                b_sel = $signed({16'd0, cfg.rate});
            end
            MUL_PER:
            begin
                a_sel = 33'(err_reg);
                b_sel = $signed({16'd0, cfg.period});
            end
            MUL_KP:
            begin
                a_sel = $signed({2'b00, cfg.kp});
                b_sel = err_reg;
            end
            MUL_KD:
            begin
                a_sel = $signed({2'b00, cfg.kd});
                b_sel = deriv_reg;
            end
            MUL_KI:
            begin
                a_sel = $signed({2'b00, cfg.ki});
                b_sel = integral_reg;
            end
            default:
            begin
                a_sel = '0;
                b_sel = '0;
            end
        endcase
    end

    assign mul_out = ProdW'(a_sel) * ProdW'(b_sel);

    // Derivative saturation from the rate product
    assign deriv_ovf = !((&prod_reg[ProdW-1:DataW-1]) || !(|prod_reg[ProdW-1:DataW-1]));
    assign deriv_sat = deriv_ovf ? (prod_reg[ProdW-1] ? SatMin : SatMax)
                                 : prod_reg[DataW-1:0];

    // Integral step and symmetric clamp
    assign incr          = prod_reg[47:16];
    assign integ_wide    = 33'(integral_reg) + 33'(incr);
    assign lim_pos33     = $signed({2'b00, cfg.limit});
    assign lim_neg33     = -lim_pos33;
    assign integ_clamped = (integ_wide > lim_pos33) ? lim_pos33[DataW-1:0]
                         : (integ_wide < lim_neg33) ? lim_neg33[DataW-1:0]
                         : integ_wide[DataW-1:0];

    // Gain term: floor of product over 2^16
    assign term = prod_reg[ProdW-1:16];

    // Final saturate and clamp
    assign acc_ovf   = !((&acc_reg[AccW-1:DataW-1]) || !(|acc_reg[AccW-1:DataW-1]));
    assign acc_sat   = acc_ovf ? (acc_reg[AccW-1] ? SatMin : SatMax) : acc_reg[DataW-1:0];
    assign lim_pos32 = $signed({1'b0, cfg.limit});
    assign lim_neg32 = -lim_pos32;
    assign drive_clamped = (acc_sat > lim_pos32) ? lim_pos32
                         : (acc_sat < lim_neg32) ? lim_neg32 : acc_sat;

    // Loop state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_meas_reg <= '0;
            integral_reg  <= '0;
        end
        else
        begin
            if (cmd.capture)
            begin
                prev_meas_reg <= measured;
            end
            if (cmd.clear)
            begin
                integral_reg <= '0;
            end
            else if (cmd.save_integ)
            begin
                integral_reg <= integ_clamped;
            end
        end
    end

    // Working and output registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            err_reg  <= err_sat;
            diff_reg <= 33'(measured) - 33'(prev_meas_reg);
        end
        if (cmd.mul_en)
        begin
            prod_reg <= mul_out;
        end
        if (cmd.save_deriv)
        begin
            deriv_reg <= deriv_sat;
        end
        if (cmd.acc_load)
        begin
            acc_reg <= term;
        end
        else if (cmd.acc_add)
        begin
            acc_reg <= acc_reg + term;
        end
        if (cmd.out_load)
        begin
            if (cmd.out_zero)
            begin
                drive_reg     <= '0;
                err_out_reg   <= '0;
                integ_out_reg <= '0;
            end
            else
            begin
                drive_reg     <= drive_clamped;
                err_out_reg   <= err_reg;
                integ_out_reg <= integral_reg;
            end
        end
    end

    assign drive          = drive_reg;
    assign error_value    = err_out_reg;
    assign integral_value = integ_out_reg;

    // A clear item leaves the integral at zero
    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> integral_reg == '0)
        else $error("integral not cleared");

    // The previous measurement moves only on a captured sample
    a_prev_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.capture |=> $stable(prev_meas_reg))
        else $error("previous measurement changed without a sample");

endmodule
`default_nettype wire

@@ design/pid_clamped_integrator.sv @@
// Top level of the PID controller step with clamped integrator.
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  cfg     | cfg_write_en         | cfg_index, cfg_data
//  in      | in_valid / in_stall  | action, measured, setpoint
//  out     | out_valid / out_stall| drive, error_value, integral_value
//
// An update item holds the block from its accept cycle on through five steps on
// the single shared 33x32 multiplier, the final sum and the output load, and its
// result sits in the output register once that load is done. A clear item holds
// the block until its zeroed result is loaded. One item is in work at a time; the
// output register lets the next item be accepted while a result waits to be taken.
// Reset puts the gains, rate, period and limit at their defaults and zeroes
// the previous measurement and integral. A stalled output holds the finished
// item in its last step until the output register frees up.
`timescale 1ns / 1ps
`default_nettype none
module pid_clamped_integrator (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write_en,
    input  wire logic [pci_pkg::IdxW-1:0]      cfg_index,
    input  wire logic [pci_pkg::GainW-1:0]     cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          action,
    input  wire logic signed [pci_pkg::DataW-1:0] measured,
    input  wire logic signed [pci_pkg::DataW-1:0] setpoint,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic signed [pci_pkg::DataW-1:0]   drive,
    output logic signed [pci_pkg::DataW-1:0]   error_value,
    output logic signed [pci_pkg::DataW-1:0]   integral_value
);
    import pci_pkg::*;

    cfg_t cfg;
    cmd_t cmd;

    // Configuration registers
    pci_regs u_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    // Step sequencer
    pci_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .action    (action),
        .out_stall (out_stall),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    // Arithmetic
    pci_dpath u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cfg            (cfg),
        .measured       (measured),
        .setpoint       (setpoint),
        .drive          (drive),
        .error_value    (error_value),
        .integral_value (integral_value)
    );

endmodule
`default_nettype wire

@@ tb/tb_pid_clamped_integrator.sv @@
// Self-checking testbench for the clamped-integrator PID step: random traffic, cycle-level checks.
`timescale 1ns / 1ps
module tb_pid_clamped_integrator;
    import pci_pkg::*;

    // Item action codes
    localparam logic ActUpdate = 1'b0;
    localparam logic ActClear  = 1'b1;

    // Indexes past the register list; writes there must do nothing
    localparam logic [IdxW-1:0] RegSpareA = 3'd6;
    localparam logic [IdxW-1:0] RegSpareB = 3'd7;

    localparam int unsigned LimitCycles = 400_000;
    localparam int          ChunkItems  = 200;
    localparam int          ChunkCount  = 8;
    localparam int          LongHold    = 300;

    typedef struct packed {
        logic                    act;
        logic signed [DataW-1:0] meas;
        logic signed [DataW-1:0] target;
    } sample_t;

    typedef struct packed {
        logic signed [DataW-1:0] drive;
        logic signed [DataW-1:0] err;
        logic signed [DataW-1:0] integ;
    } controller_out_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                    cfg_write_en = 1'b0;
    logic [IdxW-1:0]         cfg_index = '0;
    logic [GainW-1:0]        cfg_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic                    action = ActUpdate;
    logic signed [DataW-1:0] measured = '0;
    logic signed [DataW-1:0] setpoint = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic signed [DataW-1:0] drive;
    logic signed [DataW-1:0] error_value;
    logic signed [DataW-1:0] integral_value;

    pid_clamped_integrator dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .measured       (measured),
        .setpoint       (setpoint),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .drive          (drive),
        .error_value    (error_value),
        .integral_value (integral_value)
    );

    // Register shadow copy
    logic [GainW-1:0] kp_gain   = KpReset;
    logic [GainW-1:0] ki_gain   = KiReset;
    logic [GainW-1:0] kd_gain   = KdReset;
    logic [RateW-1:0] rate_hz   = RateReset;
    logic [RateW-1:0] period_q  = PeriodReset;
    logic [GainW-1:0] limit_q   = LimitReset;

    // Controller state copy
    longint prev_meas = 0;
    longint integ_acc = 0;

    sample_t         sample_queue[$];
    controller_out_t expected_outputs[$];
    sample_t         offered;
    controller_out_t oldest_output;

    int          error_count = 0;
    int unsigned cycle_count = 0;
    logic        long_hold_req = 1'b0;
    logic        long_hold_done = 1'b0;
    int          hold_cycles = 0;
    logic        quiet_window;

    assign quiet_window = (cycle_count >= 4000) && (cycle_count < 7000);

    // Clock
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic longint sat_word(input longint x);
        if (x > longint'(SatMax))
            return longint'(SatMax);
        if (x < longint'(SatMin))
            return longint'(SatMin);
        return x;
    endfunction

    function automatic longint clamp_sym(input longint x, input longint lim);
        if (x > lim)
            return lim;
        if (x < -lim)
            return -lim;
        return x;
    endfunction

    // One controller step on the shadow state; arithmetic shifts give floor(x / 2^16)
    function automatic controller_out_t controller_step(input sample_t s);
        controller_out_t r;
        longint meas_v, err_v, deriv_v, integ_v, sum_v, lim_v;
        r = '0;
        lim_v = longint'(limit_q);
        if (s.act == ActClear) begin
            integ_acc = 0;
            return r;
        end
        meas_v = longint'(s.meas);
        err_v = sat_word(longint'(s.target) - meas_v);
        deriv_v = sat_word((meas_v - prev_meas) * longint'(rate_hz));
        prev_meas = meas_v;
        integ_v = clamp_sym(integ_acc + ((err_v * longint'(period_q)) >>> 16), lim_v);
        integ_acc = integ_v;
        sum_v = ((longint'(kp_gain) * err_v) >>> 16)
              + ((longint'(kd_gain) * deriv_v) >>> 16)
              + ((longint'(ki_gain) * integ_v) >>> 16);
        sum_v = clamp_sym(sat_word(sum_v), lim_v);
        r.drive = sum_v[DataW-1:0];
        r.err = err_v[DataW-1:0];
        r.integ = integ_v[DataW-1:0];
        return r;
    endfunction

    // Full-range values, values near a reference, values within +/-2^20, and extremes
    function automatic logic signed [DataW-1:0] random_value(input logic signed [DataW-1:0] near);
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 30)
            return $urandom;
        if (pick < 60)
            return near + $signed($urandom_range(262144)) - 131072;
        if (pick < 85)
            return $signed($urandom_range(2097152)) - 1048576;
        case ($urandom_range(4))
            0: return SatMin;
            1: return SatMax;
            2: return 0;
            3: return -1;
            default: return 1;
        endcase
    endfunction

    task automatic queue_sample(input logic act, input logic signed [DataW-1:0] meas,
                                input logic signed [DataW-1:0] target);
        sample_t s;
        s.act = act;
        s.meas = meas;
        s.target = target;
        sample_queue.push_back(s);
    endtask

    task automatic write_reg(input logic [IdxW-1:0] idx, input logic [GainW-1:0] value);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            RegKp:     kp_gain = value;
            RegKi:     ki_gain = value;
            RegKd:     kd_gain = value;
            RegRate:   rate_hz = value[RateW-1:0];
            RegPeriod: period_q = value[RateW-1:0];
            RegLimit:  limit_q = value;
            default:   ;
        endcase
    endtask

    // Full register set plus the two unused indexes; only called while idle
    task automatic apply_settings(input logic [GainW-1:0] kp, input logic [GainW-1:0] ki,
                                  input logic [GainW-1:0] kd, input logic [GainW-1:0] rate,
                                  input logic [GainW-1:0] period,
                                  input logic [GainW-1:0] limit);
        write_reg(RegSpareA, $urandom);
        write_reg(RegKp, kp);
        write_reg(RegKi, ki);
        write_reg(RegKd, kd);
        write_reg(RegRate, rate);
        write_reg(RegPeriod, period);
        write_reg(RegLimit, limit);
        write_reg(RegSpareB, $urandom);
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    // Wait until every queued item went in and every result came back
    task automatic drain();
        @(negedge clk);
        while (sample_queue.size() != 0 || in_valid || expected_outputs.size() != 0)
            @(negedge clk);
        repeat (12) @(negedge clk);
    endtask

    // Sender: holds a stalled item, idles at random otherwise
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end
        else begin
            if (in_valid && !in_stall)
                expected_outputs.push_back(controller_step(offered));
            if (!(in_valid && in_stall)) begin
                if (sample_queue.size() != 0 && (quiet_window || $urandom_range(99) >= 12))
                begin
                    offered = sample_queue.pop_front();
                    in_valid <= 1'b1;
                    action <= offered.act;
                    measured <= offered.meas;
                    setpoint <= offered.target;
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver back-pressure, with one long hold-off on request
    always @(posedge clk) begin
        if (hold_cycles != 0) begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else if (long_hold_req && !long_hold_done) begin
            out_stall <= 1'b1;
            hold_cycles <= LongHold;
            long_hold_done <= 1'b1;
        end
        else begin
            out_stall <= !quiet_window && ($urandom_range(99) < 12);
        end
    end

    task automatic check_field(input string name, input logic signed [DataW-1:0] want,
                               input logic signed [DataW-1:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    // Result checker
    always @(posedge clk) begin
        if (rst_n && out_valid === 1'b1 && !out_stall) begin
            if (expected_outputs.size() == 0) begin
                $display("%0t ns: unexpected item, expected none, got drive %0d", $time, drive);
                error_count++;
            end
            else begin
                oldest_output = expected_outputs.pop_front();
                check_field("drive", oldest_output.drive, drive);
                check_field("error_value", oldest_output.err, error_value);
                check_field("integral_value", oldest_output.integ, integral_value);
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LimitCycles) begin
            $display("tb_pid_clamped_integrator NOT OK");
            $finish;
        end
    end

    // Stimulus sequence
    initial begin
        logic signed [DataW-1:0] last_meas;
        logic signed [DataW-1:0] meas_v;
        last_meas = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Reset defaults: error saturation both ways, clear item
        queue_sample(ActUpdate, 0, 0);
        queue_sample(ActUpdate, 0, 32'sh0001_0000);
        queue_sample(ActUpdate, SatMax, SatMin);
        queue_sample(ActUpdate, SatMin, SatMax);
        queue_sample(ActClear, $urandom, $urandom);
        queue_sample(ActUpdate, -1, -1);
        drain();

        // All terms active; upper bits of rate and period data must be masked off
        apply_settings(31'h0001_8000, 31'h0002_0000, 31'h0000_0800, 31'h7FFF_0064,
                       31'h5A5A_0CCD, 31'h0005_0000);
        queue_sample(ActUpdate, SatMin, SatMin);
        queue_sample(ActUpdate, SatMax, SatMax);
        queue_sample(ActUpdate, SatMax, SatMin);
        queue_sample(ActUpdate, 0, SatMax);
        queue_sample(ActUpdate, 0, SatMax);
        queue_sample(ActClear, SatMax, SatMin);
        queue_sample(ActUpdate, 0, SatMin);
        drain();

        // Zero rate, period and limit: integral and drive forced to zero
        apply_settings({GainW{1'b1}}, {GainW{1'b1}}, {GainW{1'b1}}, 31'h0001_0000,
                       31'h0001_0000, 31'h0);
        queue_sample(ActUpdate, 32'sh1234_5678, 32'shEDCB_A988);
        queue_sample(ActUpdate, SatMin, SatMax);
        drain();

        // Everything at its maximum
        apply_settings({GainW{1'b1}}, {GainW{1'b1}}, {GainW{1'b1}}, {GainW{1'b1}},
                       {GainW{1'b1}}, {GainW{1'b1}});
        queue_sample(ActUpdate, SatMin, SatMax);
        queue_sample(ActUpdate, SatMax, SatMin);
        queue_sample(ActUpdate, 0, 0);
        queue_sample(ActClear, 0, 0);
        drain();

        // Random part, one register setting per chunk
        for (int c = 0; c < ChunkCount; c++) begin
            case (c % 5)
                0: apply_settings($urandom_range(262144), $urandom_range(262144),
                                  $urandom_range(6554), $urandom_range(1000, 1),
                                  $urandom_range(65535, 65), $urandom_range(16777216, 1));
                1: apply_settings({GainW{1'b1}}, {GainW{1'b1}}, {GainW{1'b1}},
                                  {GainW{1'b1}}, {GainW{1'b1}}, {GainW{1'b1}});
                2: apply_settings($urandom, $urandom, $urandom, $urandom, $urandom,
                                  $urandom);
                3: apply_settings($urandom, $urandom, $urandom, 31'h0001_0000,
                                  31'h0002_0000, 31'h0);
                default: apply_settings($urandom_range(1048576), $urandom_range(1048576),
                                        $urandom_range(1048576), $urandom_range(65535),
                                        $urandom_range(65535), $urandom_range(65536));
            endcase
            for (int n = 0; n < ChunkItems; n++) begin
                if ($urandom_range(99) < 6) begin
                    queue_sample(ActClear, $urandom, $urandom);
                end
                else begin
                    meas_v = random_value(last_meas);
                    queue_sample(ActUpdate, meas_v, random_value(meas_v));
                    last_meas = meas_v;
                end
            end
            // Hold the receiver off while this chunk is being offered
            if (c == 2)
                long_hold_req = 1'b1;
            drain();
        end

        if (error_count == 0)
            $display("tb_pid_clamped_integrator OK");
        else
            $display("tb_pid_clamped_integrator NOT OK");
        $finish;
    end

endmodule
